>>> rtl/guillotine_rect_allocator_core_macros.svh
// Assertion macros for the guillotine allocator checker.
// Used by the checker file only; no other dependencies.
`ifndef GUILLOTINE_RECT_ALLOCATOR_CORE_MACROS_SVH
`define GUILLOTINE_RECT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GRA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("guillotine allocator check failed");

// Next-cycle implication, sampled on clk, off during reset
`define GRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("guillotine allocator check failed");

`endif

>>> rtl/grac_pkg.sv
// Shared types and constants for the guillotine rectangle allocator.
// No dependencies; imported by all modules of the block except grac_ram.
package grac_pkg;

  localparam int FREE_SLOTS = 64;
  localparam int COORD_BITS = 12;
  localparam int DIM_W      = COORD_BITS + 1;
  localparam int IDX_W      = $clog2(FREE_SLOTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int SCORE_W    = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1 << COORD_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLACEMENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;

  // Placement rule codes
  localparam logic [2:0] PR_BEST_AREA   = 3'd0;
  localparam logic [2:0] PR_BEST_SHORT  = 3'd1;
  localparam logic [2:0] PR_BEST_LONG   = 3'd2;
  localparam logic [2:0] PR_WORST_AREA  = 3'd3;
  localparam logic [2:0] PR_WORST_SHORT = 3'd4;
  localparam logic [2:0] PR_WORST_LONG  = 3'd5;

  // Split rule codes
  localparam logic [2:0] SR_SHORTER_LEFT = 3'd0;
  localparam logic [2:0] SR_LONGER_LEFT  = 3'd1;
  localparam logic [2:0] SR_MIN_AREA     = 3'd2;
  localparam logic [2:0] SR_MAX_AREA     = 3'd3;
  localparam logic [2:0] SR_SHORTER_AXIS = 3'd4;
  localparam logic [2:0] SR_LONGER_AXIS  = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } frect_t;

  localparam int ENTRY_W = $bits(frect_t);

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_CLEAR,
    OP_LOAD,
    OP_ITEM_MUL,
    OP_SCAN_RD,
    OP_SCAN_MUL,
    OP_SCAN_CMP,
    OP_SPLIT_MUL_A,
    OP_SPLIT_MUL_B,
    OP_SPLIT_DIR,
    OP_RM_RD,
    OP_RM_WR,
    OP_RM_END,
    OP_APP_LOWER,
    OP_APP_RIGHT,
    OP_MI_RD,
    OP_MI_LOAD,
    OP_MJ_RD,
    OP_MJ_CMP,
    OP_MI_NEXT,
    OP_RES_PLACED,
    OP_RES_NOFIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_size;
    logic scan_end;
    logic exact;
    logic found;
    logic rm_last;
    logic i_end;
    logic j_end;
    logic joined;
    logic merge_en;
  } dp_status_t;

endpackage

>>> rtl/guillotine_rect_allocator_core.sv
// Guillotine rectangle allocator for a 2D atlas with a 64-entry free list in one
// single-port-read RAM. Issue a word with start while busy is low; the result word
// appears for exactly one cycle with done high and cannot be stalled, so capture it
// then. A clear is answered in the next cycle. An insert loads the size, checks it
// and takes the item area, then scans the free entries, each read, multiplied and
// compared (an exact fit ends the scan early); it then chooses the split, removes the
// chosen entry by moving each later entry down, appends the lower and right parts,
// and with merging takes each entry as the first of a pair, compares it with each
// later entry, and on each join removes the later entry the same way; the result
// word is registered after the last step. Every step is bounded by the one read and
// one write the free list RAM offers per cycle. After reset the block is busy while
// it writes the initial atlas entry. Depends on grac_pkg, grac_ctrl, grac_dp.
module guillotine_rect_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [grac_pkg::DIM_W-1:0]        rect_width,
  input  logic [grac_pkg::DIM_W-1:0]        rect_height,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [grac_pkg::COORD_BITS-1:0]   pos_x,
  output logic [grac_pkg::COORD_BITS-1:0]   pos_y,
  output logic [grac_pkg::DIM_W-1:0]        placed_width,
  output logic [grac_pkg::DIM_W-1:0]        placed_height,
  output logic                              rotated,
  output logic                              list_overflow,
  input  logic                              cfg_we,
  input  logic [grac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [grac_pkg::DIM_W-1:0]        cfg_data
);
  import grac_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  grac_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  grac_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .done          (done),
    .status        (status),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .placed_width  (placed_width),
    .placed_height (placed_height),
    .rotated       (rotated),
    .list_overflow (list_overflow)
  );

endmodule

>>> rtl/grac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/grac_ctrl.sv
// Sequencer for clear, insert scan, split, removal, append and merge.
// Depends on grac_pkg; drives grac_dp through dp_cmd_t.
module grac_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  grac_pkg::dp_status_t stat,
  output grac_pkg::dp_cmd_t   cmd,
  output logic                busy
);
  import grac_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CHECK, S_SCAN, S_SMUL, S_SCMP, S_SPLA, S_SPLB, S_SDIR,
    S_RM, S_RMW, S_APPL, S_APPR, S_FIN, S_MI, S_MIL, S_MJ, S_MJC
  } state_t;

  state_t state, state_next;
  logic   rm_merge, rm_merge_next;

  // Next state and operation
  always_comb begin
    state_next    = state;
    rm_merge_next = rm_merge;
    cmd.op        = OP_NONE;
    case (state)
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (command) begin
            cmd.op = OP_CLEAR;
          end else begin
            cmd.op     = OP_LOAD;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.zero_size) begin
          cmd.op     = OP_RES_NOFIT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_ITEM_MUL;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          if (stat.found) begin
            state_next = S_SPLA;
          end else begin
            cmd.op     = OP_RES_NOFIT;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_SMUL;
        end
      end
      S_SMUL: begin
        cmd.op     = OP_SCAN_MUL;
        state_next = stat.exact ? S_SPLA : S_SCMP;
      end
      S_SCMP: begin
        cmd.op     = OP_SCAN_CMP;
        state_next = S_SCAN;
      end
      S_SPLA: begin
        cmd.op     = OP_SPLIT_MUL_A;
        state_next = S_SPLB;
      end
      S_SPLB: begin
        cmd.op     = OP_SPLIT_MUL_B;
        state_next = S_SDIR;
      end
      S_SDIR: begin
        cmd.op        = OP_SPLIT_DIR;
        rm_merge_next = 1'b0;
        state_next    = S_RM;
      end
      S_RM: begin
        if (stat.rm_last) begin
          cmd.op     = OP_RM_END;
          state_next = rm_merge ? S_MJ : S_APPL;
        end else begin
          cmd.op     = OP_RM_RD;
          state_next = S_RMW;
        end
      end
      S_RMW: begin
        cmd.op     = OP_RM_WR;
        state_next = S_RM;
      end
      S_APPL: begin
        cmd.op     = OP_APP_LOWER;
        state_next = S_APPR;
      end
      S_APPR: begin
        cmd.op     = OP_APP_RIGHT;
        state_next = stat.merge_en ? S_MI : S_FIN;
      end
      S_FIN: begin
        cmd.op     = OP_RES_PLACED;
        state_next = S_IDLE;
      end
      S_MI: begin
        if (stat.i_end) begin
          cmd.op     = OP_RES_PLACED;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_MI_RD;
          state_next = S_MIL;
        end
      end
      S_MIL: begin
        cmd.op     = OP_MI_LOAD;
        state_next = S_MJ;
      end
      S_MJ: begin
        if (stat.j_end) begin
          cmd.op     = OP_MI_NEXT;
          state_next = S_MI;
        end else begin
          cmd.op     = OP_MJ_RD;
          state_next = S_MJC;
        end
      end
      S_MJC: begin
        cmd.op = OP_MJ_CMP;
        if (stat.joined) begin
          rm_merge_next = 1'b1;
          state_next    = S_RM;
        end else begin
          state_next = S_MJ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and removal return flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      rm_merge <= 1'b0;
    end else begin
      state    <= state_next;
      rm_merge <= rm_merge_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

>>> rtl/grac_dp.sv
// Datapath: configuration registers, free list RAM, counters, scorer,
// shared multiplier, split and merge logic, result registers.
// Depends on grac_pkg and grac_ram; controlled by grac_ctrl.
module grac_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  grac_pkg::dp_cmd_t                 cmd,
  output grac_pkg::dp_status_t              stat,
  input  logic                              cfg_we,
  input  logic [grac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [grac_pkg::DIM_W-1:0]        cfg_data,
  input  logic [grac_pkg::DIM_W-1:0]        rect_width,
  input  logic [grac_pkg::DIM_W-1:0]        rect_height,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [grac_pkg::COORD_BITS-1:0]   pos_x,
  output logic [grac_pkg::COORD_BITS-1:0]   pos_y,
  output logic [grac_pkg::DIM_W-1:0]        placed_width,
  output logic [grac_pkg::DIM_W-1:0]        placed_height,
  output logic                              rotated,
  output logic                              list_overflow
);
  import grac_pkg::*;

  // Configuration
  logic [DIM_W-1:0] atlas_w, atlas_h;
  logic             rot_en, merge_en;
  logic [2:0]       prule, srule;

  // Item and scan state
  logic [DIM_W-1:0]         req_w, req_h;
  logic [CNT_W-1:0]         count, ci, cj, ck;
  logic                     found, rot, ovf, horiz;
  logic signed [SCORE_W-1:0] best;
  logic [CNT_W-1:0]         best_idx;
  logic [DIM_W-1:0]         pw, ph;
  frect_t                   sel, acc;
  logic [PROD_W-1:0]        prod, prod_b, item_area;

  // RAM ports
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  frect_t             ram_wdata, cand;
  logic [ENTRY_W-1:0] ram_rdata;

  grac_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cand = frect_t'(ram_rdata);

  // Saturated atlas size for clear
  logic [DIM_W-1:0] sat_w, sat_h;
  logic             atlas_ok;
  assign sat_w    = (atlas_w > DIM_MAX) ? DIM_MAX : atlas_w;
  assign sat_h    = (atlas_h > DIM_MAX) ? DIM_MAX : atlas_h;
  assign atlas_ok = (sat_w != '0) && (sat_h != '0);

  // Split leftovers and parts
  logic [DIM_W-1:0] wl, hl;
  frect_t           lower, right;
  logic             lower_ok, right_ok, list_full;
  assign wl = sel.w - pw;
  assign hl = sel.h - ph;
  always_comb begin
    lower.x = sel.x;
    lower.y = sel.y + ph;
    lower.w = horiz ? sel.w : pw;
    lower.h = hl;
    right.x = sel.x + pw;
    right.y = sel.y;
    right.w = wl;
    right.h = horiz ? ph : sel.h;
  end
  assign lower_ok  = (lower.w != '0) && (lower.h != '0);
  assign right_ok  = (right.w != '0) && (right.h != '0);
  assign list_full = (count >= CNT_W'(FREE_SLOTS));

  // Shared multiplier with operand select
  logic [DIM_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    case (cmd.op)
      OP_ITEM_MUL:    begin mul_a = req_w; mul_b = req_h; end
      OP_SCAN_MUL:    begin mul_a = cand.w; mul_b = cand.h; end
      OP_SPLIT_MUL_A: begin mul_a = pw; mul_b = hl; end
      OP_SPLIT_MUL_B: begin mul_a = ph; mul_b = wl; end
      default:        begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Exact fit check on the word just read
  logic ex_up, ex_rot;
  assign ex_up  = (req_w == cand.w) && (req_h == cand.h);
  assign ex_rot = rot_en && (req_w == cand.h) && (req_h == cand.w);

  // Fit and score of the candidate
  logic                      fit_up, fit_rot, fit_any;
  logic [DIM_W-1:0]          dw, dh, mn, mx;
  logic [PROD_W:0]           area;
  logic signed [SCORE_W-1:0] score;
  logic                      take;
  always_comb begin
    fit_up  = (req_w <= cand.w) && (req_h <= cand.h);
    fit_rot = rot_en && (req_h <= cand.w) && (req_w <= cand.h);
    fit_any = fit_up || fit_rot;
    dw      = fit_up ? (cand.w - req_w) : (cand.w - req_h);
    dh      = fit_up ? (cand.h - req_h) : (cand.h - req_w);
    mn      = (dw < dh) ? dw : dh;
    mx      = (dw < dh) ? dh : dw;
    area    = {1'b0, prod} - {1'b0, item_area};
    case (prule)
      PR_BEST_AREA:   score = SCORE_W'(area);
      PR_BEST_SHORT:  score = SCORE_W'(mn);
      PR_BEST_LONG:   score = SCORE_W'(mx);
      PR_WORST_AREA:  score = -SCORE_W'(area);
      PR_WORST_SHORT: score = -SCORE_W'(mn);
      default:        score = -SCORE_W'(mx);
    endcase
    take = fit_any && (prule <= PR_WORST_LONG) && (!found || (score < best));
  end

  // Split direction
  logic horiz_next;
  always_comb begin
    case (srule)
      SR_SHORTER_LEFT: horiz_next = (wl <= hl);
      SR_LONGER_LEFT:  horiz_next = (wl > hl);
      SR_MIN_AREA:     horiz_next = (prod > prod_b);
      SR_MAX_AREA:     horiz_next = (prod <= prod_b);
      SR_SHORTER_AXIS: horiz_next = (sel.w <= sel.h);
      SR_LONGER_AXIS:  horiz_next = (sel.w > sel.h);
      default:         horiz_next = 1'b1;
    endcase
  end

  // Merge test of held entry against the word just read
  logic [DIM_W:0] b_end_y, a_end_y, b_end_x, a_end_x;
  logic           joined;
  frect_t         merged;
  always_comb begin
    b_end_y = {1'b0, cand.y} + {1'b0, cand.h};
    a_end_y = {1'b0, acc.y} + {1'b0, acc.h};
    b_end_x = {1'b0, cand.x} + {1'b0, cand.w};
    a_end_x = {1'b0, acc.x} + {1'b0, acc.w};
    merged  = acc;
    joined  = 1'b0;
    if ((acc.w == cand.w) && (acc.x == cand.x)) begin
      if ({1'b0, acc.y} == b_end_y) begin
        merged.y = acc.y - cand.h;
        merged.h = acc.h + cand.h;
        joined   = 1'b1;
      end else if (a_end_y == {1'b0, cand.y}) begin
        merged.h = acc.h + cand.h;
        joined   = 1'b1;
      end
    end else if ((acc.h == cand.h) && (acc.y == cand.y)) begin
      if ({1'b0, acc.x} == b_end_x) begin
        merged.x = acc.x - cand.w;
        merged.w = acc.w + cand.w;
        joined   = 1'b1;
      end else if (a_end_x == {1'b0, cand.x}) begin
        merged.w = acc.w + cand.w;
        joined   = 1'b1;
      end
    end
  end

  // RAM access by operation
  logic [CNT_W-1:0] ck_inc;
  assign ck_inc = CNT_W'(ck + 1'b1);
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (cmd.op)
      OP_INIT, OP_CLEAR: begin
        ram_we    = atlas_ok;
        ram_wdata = '{x: '0, y: '0, w: sat_w, h: sat_h};
      end
      OP_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ci[IDX_W-1:0];
      end
      OP_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ck_inc[IDX_W-1:0];
      end
      OP_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ck[IDX_W-1:0];
        ram_wdata = cand;
      end
      OP_APP_LOWER: begin
        ram_we    = lower_ok && !list_full;
        ram_waddr = count[IDX_W-1:0];
        ram_wdata = lower;
      end
      OP_APP_RIGHT: begin
        ram_we    = right_ok && !list_full;
        ram_waddr = count[IDX_W-1:0];
        ram_wdata = right;
      end
      OP_MI_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ci[IDX_W-1:0];
      end
      OP_MJ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cj[IDX_W-1:0];
      end
      OP_MJ_CMP: begin
        ram_we    = joined;
        ram_waddr = ci[IDX_W-1:0];
        ram_wdata = merged;
      end
      default: begin
      end
    endcase
  end

  // Status back to the sequencer
  always_comb begin
    stat.zero_size = (req_w == '0) || (req_h == '0);
    stat.scan_end  = (ci >= count);
    stat.exact     = ex_up || ex_rot;
    stat.found     = found;
    stat.rm_last   = (ck_inc >= count);
    stat.i_end     = (ci >= count);
    stat.j_end     = (cj >= count);
    stat.joined    = joined;
    stat.merge_en  = merge_en;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w  <= DIM_MAX;
      atlas_h  <= DIM_MAX;
      rot_en   <= 1'b0;
      merge_en <= 1'b1;
      prule    <= PR_BEST_AREA;
      srule    <= SR_MIN_AREA;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATLAS_W:   atlas_w  <= cfg_data;
        REG_ATLAS_H:   atlas_h  <= cfg_data;
        REG_ROTATE:    rot_en   <= cfg_data[0];
        REG_MERGE:     merge_en <= cfg_data[0];
        REG_PLACEMENT: prule    <= cfg_data[2:0];
        REG_SPLIT:     srule    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Counters and list length
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ci    <= '0;
      cj    <= '0;
      ck    <= '0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        OP_INIT: begin
          count <= atlas_ok ? CNT_W'(1) : '0;
        end
        OP_CLEAR: begin
          count <= atlas_ok ? CNT_W'(1) : '0;
          done  <= 1'b1;
        end
        OP_LOAD: begin
          ci    <= '0;
          found <= 1'b0;
        end
        OP_SCAN_MUL: begin
          if (ex_up || ex_rot) begin
            found <= 1'b1;
            ck    <= ci;
          end
        end
        OP_SCAN_CMP: begin
          if (take) begin
            found <= 1'b1;
          end
          ci <= CNT_W'(ci + 1'b1);
        end
        OP_SPLIT_DIR: ck <= best_idx;
        OP_RM_WR:     ck <= ck_inc;
        OP_RM_END:    count <= CNT_W'(count - 1'b1);
        OP_APP_LOWER: begin
          if (lower_ok && !list_full) begin
            count <= CNT_W'(count + 1'b1);
          end
        end
        OP_APP_RIGHT: begin
          if (right_ok && !list_full) begin
            count <= CNT_W'(count + 1'b1);
          end
          ci <= '0;
        end
        OP_MI_LOAD: cj <= CNT_W'(ci + 1'b1);
        OP_MJ_CMP: begin
          if (joined) begin
            ck <= cj;
          end else begin
            cj <= CNT_W'(cj + 1'b1);
          end
        end
        OP_MI_NEXT:    ci   <= CNT_W'(ci + 1'b1);
        OP_RES_PLACED: done <= 1'b1;
        OP_RES_NOFIT:  done <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Payload registers: item, selection, products, results
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLEAR: begin
        status        <= ST_CLEARED;
        pos_x         <= '0;
        pos_y         <= '0;
        placed_width  <= '0;
        placed_height <= '0;
        rotated       <= 1'b0;
        list_overflow <= 1'b0;
      end
      OP_LOAD: begin
        req_w <= rect_width;
        req_h <= rect_height;
        ovf   <= 1'b0;
      end
      OP_ITEM_MUL: item_area <= mul_p;
      OP_SCAN_MUL: begin
        prod <= mul_p;
        if (ex_up || ex_rot) begin
          sel      <= cand;
          best_idx <= ci;
          rot      <= !ex_up;
          pw       <= ex_up ? req_w : req_h;
          ph       <= ex_up ? req_h : req_w;
        end
      end
      OP_SCAN_CMP: begin
        if (take) begin
          best     <= score;
          sel      <= cand;
          best_idx <= ci;
          rot      <= !fit_up;
          pw       <= fit_up ? req_w : req_h;
          ph       <= fit_up ? req_h : req_w;
        end
      end
      OP_SPLIT_MUL_A: prod   <= mul_p;
      OP_SPLIT_MUL_B: prod_b <= mul_p;
      OP_SPLIT_DIR:   horiz  <= horiz_next;
      OP_APP_LOWER: begin
        if (lower_ok && list_full) begin
          ovf <= 1'b1;
        end
      end
      OP_APP_RIGHT: begin
        if (right_ok && list_full) begin
          ovf <= 1'b1;
        end
      end
      OP_MI_LOAD: acc <= cand;
      OP_MJ_CMP: begin
        if (joined) begin
          acc <= merged;
        end
      end
      OP_RES_PLACED: begin
        status        <= ST_PLACED;
        pos_x         <= sel.x[COORD_BITS-1:0];
        pos_y         <= sel.y[COORD_BITS-1:0];
        placed_width  <= pw;
        placed_height <= ph;
        rotated       <= rot;
        list_overflow <= ovf;
      end
      OP_RES_NOFIT: begin
        status        <= ST_NOFIT;
        pos_x         <= '0;
        pos_y         <= '0;
        placed_width  <= '0;
        placed_height <= '0;
        rotated       <= 1'b0;
        list_overflow <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/grac_checker.sv
// Port-level checks for the guillotine allocator, bound to the top level.
// Depends on grac_pkg and guillotine_rect_allocator_core_macros.svh.
`include "guillotine_rect_allocator_core_macros.svh"

module grac_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            command,
  input logic                            done,
  input logic [1:0]                      status,
  input logic [grac_pkg::COORD_BITS-1:0] pos_x,
  input logic [grac_pkg::DIM_W-1:0]      placed_width,
  input logic [grac_pkg::DIM_W-1:0]      placed_height,
  input logic                            rotated,
  input logic                            list_overflow
);
  import grac_pkg::*;

  // A clear word answers in the next cycle
  `GRA_ASSERT_NEXT(a_clear_next, start && !busy && command, done && (status == ST_CLEARED))

  // A result word follows work in flight or an accepted word
  `GRA_ASSERT_IMPL(a_done_cause, done, $past(busy) || $past(start))

  // Placed words carry a nonzero size
  `GRA_ASSERT_IMPL(a_placed_size, done && (status == ST_PLACED),
                   (placed_width != '0) && (placed_height != '0))

  // Words that place nothing carry zero x, width, rotation and overflow fields
  `GRA_ASSERT_IMPL(a_unplaced_zero, done && (status != ST_PLACED),
                   (pos_x == '0) && (placed_width == '0) && !rotated && !list_overflow)

endmodule

bind guillotine_rect_allocator_core grac_checker u_grac_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .command       (command),
  .done          (done),
  .status        (status),
  .pos_x         (pos_x),
  .placed_width  (placed_width),
  .placed_height (placed_height),
  .rotated       (rotated),
  .list_overflow (list_overflow)
);

>>> bench/tb_top.sv
// Self-checking bench for guillotine_rect_allocator_core: a free-list predictor
// mirrors every insert and clear and checks each result word. Depends on grac_pkg.
module tb_top;
  import grac_pkg::*;

  typedef struct packed {
    logic             command;
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] rh;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [DIM_W-1:0]      pw;
    logic [DIM_W-1:0]      ph;
    logic                  rot;
    logic                  ovf;
  } place_word_t;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } span_t;

  localparam int WATCHDOG = 40000;

  logic clk, rst, start, command, cfg_we;
  logic [DIM_W-1:0] rect_width, rect_height, cfg_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic busy, done, rotated, list_overflow;
  logic [1:0] status;
  logic [COORD_BITS-1:0] pos_x, pos_y;
  logic [DIM_W-1:0] placed_width, placed_height;

  // predictor copy of the registers and the free list
  int m_aw, m_ah, m_rot, m_merge, m_prule, m_srule;
  span_t spans[$];

  cmd_word_t   pending_words[$];
  place_word_t expected_places[$];
  int errors = 0, n_checked = 0, n_placed = 0, n_nofit = 0, n_ovf = 0, stall_cnt = 0;
  int idle_left = 0;
  bit no_idle = 0;

  // set when start was taken at the last rising edge
  logic took;

  guillotine_rect_allocator_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .rect_width(rect_width), .rect_height(rect_height), .done(done),
    .status(status), .pos_x(pos_x), .pos_y(pos_y), .placed_width(placed_width),
    .placed_height(placed_height), .rotated(rotated), .list_overflow(list_overflow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint rect_score(span_t f, int pw, int ph);
    longint dw, dh, ar, mn, mx;
    dw = f.w - pw;
    dh = f.h - ph;
    ar = longint'(f.w) * f.h - longint'(pw) * ph;
    mn = dw < dh ? dw : dh;
    mx = dw < dh ? dh : dw;
    case (m_prule)
      PR_BEST_AREA:   return ar;
      PR_BEST_SHORT:  return mn;
      PR_BEST_LONG:   return mx;
      PR_WORST_AREA:  return -ar;
      PR_WORST_SHORT: return -mn;
      default:        return -mx;
    endcase
  endfunction

  function automatic bit add_span(int x, int y, int w, int h);
    span_t s;
    if (w == 0 || h == 0) return 0;
    if (spans.size() >= FREE_SLOTS) return 1;
    s = '{x, y, w, h};
    spans.insert(spans.size(), s);
    return 0;
  endfunction

  function automatic void merge_spans();
    int i, j;
    bit joined;
    for (i = 0; i < spans.size(); i++) begin
      j = i + 1;
      while (j < spans.size()) begin
        joined = 0;
        if (spans[i].w == spans[j].w && spans[i].x == spans[j].x) begin
          if (spans[i].y == spans[j].y + spans[j].h) begin
            spans[i].y -= spans[j].h; spans[i].h += spans[j].h; joined = 1;
          end else if (spans[i].y + spans[i].h == spans[j].y) begin
            spans[i].h += spans[j].h; joined = 1;
          end
        end else if (spans[i].h == spans[j].h && spans[i].y == spans[j].y) begin
          if (spans[i].x == spans[j].x + spans[j].w) begin
            spans[i].x -= spans[j].w; spans[i].w += spans[j].w; joined = 1;
          end else if (spans[i].x + spans[i].w == spans[j].x) begin
            spans[i].w += spans[j].w; joined = 1;
          end
        end
        if (joined) spans.delete(j);
        else j++;
      end
    end
  endfunction

  function automatic void clear_spans();
    int w, h;
    w = m_aw > 4096 ? 4096 : m_aw;
    h = m_ah > 4096 ? 4096 : m_ah;
    spans.delete();
    if (w != 0 && h != 0) void'(add_span(0, 0, w, h));
  endfunction

  // compute the placement for one word and update the free list
  function automatic place_word_t place_rect(cmd_word_t c);
    place_word_t r;
    bit found, rot, ovf, horiz;
    int idx, pw, ph, w, h;
    longint best, s, wl, hl;
    span_t f;
    r = '0; found = 0; rot = 0; ovf = 0; idx = 0; pw = 0; ph = 0; best = 0;
    w = c.rw; h = c.rh;
    if (c.command) begin
      clear_spans();
      r.status = ST_CLEARED;
      return r;
    end
    if (w != 0 && h != 0) begin
      foreach (spans[i]) begin
        f = spans[i];
        if (w == f.w && h == f.h) begin
          found = 1; rot = 0; idx = i; pw = w; ph = h; break;
        end else if (m_rot != 0 && w == f.h && h == f.w) begin
          found = 1; rot = 1; idx = i; pw = h; ph = w; break;
        end else if (w <= f.w && h <= f.h) begin
          if (m_prule < 6) begin
            s = rect_score(f, w, h);
            if (!found || s < best) begin
              found = 1; best = s; rot = 0; idx = i; pw = w; ph = h;
            end
          end
        end else if (m_rot != 0 && h <= f.w && w <= f.h) begin
          if (m_prule < 6) begin
            s = rect_score(f, h, w);
            if (!found || s < best) begin
              found = 1; best = s; rot = 1; idx = i; pw = h; ph = w;
            end
          end
        end
      end
    end
    if (!found) begin
      r.status = ST_NOFIT;
      return r;
    end
    f = spans[idx];
    wl = f.w - pw;
    hl = f.h - ph;
    case (m_srule)
      SR_SHORTER_LEFT: horiz = wl <= hl;
      SR_LONGER_LEFT:  horiz = wl > hl;
      SR_MIN_AREA:     horiz = longint'(pw) * hl > longint'(ph) * wl;
      SR_MAX_AREA:     horiz = longint'(pw) * hl <= longint'(ph) * wl;
      SR_SHORTER_AXIS: horiz = f.w <= f.h;
      SR_LONGER_AXIS:  horiz = f.w > f.h;
      default:         horiz = 1;
    endcase
    spans.delete(idx);
    if (add_span(f.x, f.y + ph, horiz ? f.w : pw, int'(hl))) ovf = 1;
    if (add_span(f.x + pw, f.y, int'(wl), horiz ? ph : f.h)) ovf = 1;
    if (m_merge != 0) merge_spans();
    r.status = ST_PLACED;
    r.px = f.x[COORD_BITS-1:0];
    r.py = f.y[COORD_BITS-1:0];
    r.pw = pw[DIM_W-1:0];
    r.ph = ph[DIM_W-1:0];
    r.rot = rot;
    r.ovf = ovf;
    return r;
  endfunction

  // record whether start was taken at this rising edge
  always @(posedge clk) begin
    took <= start && !busy && !rst;
  end

  // driver: issue queued words with random idle bursts
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !took) begin
        // hold the word until accepted
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 0;
      end else if (pending_words.size() > 0) begin
        if (!no_idle && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(0, 17);
          start <= 0;
        end else begin
          cmd_word_t c;
          c = pending_words.pop_front();
          command <= c.command;
          rect_width <= c.rw;
          rect_height <= c.rh;
          start <= 1;
        end
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: predict on acceptance, check each result word
  always @(posedge clk) begin
    place_word_t got, exp_w;
    cmd_word_t c;
    if (rst) begin
      stall_cnt <= 0;
    end else begin
      if (start && !busy) begin
        c = '{command, rect_width, rect_height};
        expected_places.insert(expected_places.size(), place_rect(c));
      end
      if (done) begin
        got = '{status, pos_x, pos_y, placed_width, placed_height, rotated, list_overflow};
        if (expected_places.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          exp_w = expected_places.pop_front();
          n_checked++;
          if (exp_w.status == ST_PLACED) n_placed++;
          if (exp_w.status == ST_NOFIT) n_nofit++;
          if (exp_w.ovf) n_ovf++;
          if (got != exp_w) begin
            $display("%0t: mismatch expected st=%0d x=%0d y=%0d w=%0d h=%0d rot=%0d ovf=%0d",
                     $time, exp_w.status, exp_w.px, exp_w.py, exp_w.pw, exp_w.ph,
                     exp_w.rot, exp_w.ovf);
            $display("%0t:          actual   st=%0d x=%0d y=%0d w=%0d h=%0d rot=%0d ovf=%0d",
                     $time, got.status, got.px, got.py, got.pw, got.ph, got.rot, got.ovf);
            errors++;
          end
        end
      end
      if ((start && !busy) || done) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
    end
  end

  // watchdog on cycles with nothing accepted and no result word
  always @(posedge clk) begin
    if (stall_cnt >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[DIM_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_ATLAS_W:   m_aw = val & 13'h1fff;
      REG_ATLAS_H:   m_ah = val & 13'h1fff;
      REG_ROTATE:    m_rot = val & 1;
      REG_MERGE:     m_merge = val & 1;
      REG_PLACEMENT: m_prule = val & 7;
      default:       m_srule = val & 7;
    endcase
  endtask

  task automatic push_word(bit cmd, int w, int h);
    cmd_word_t c;
    c = '{cmd, w[DIM_W-1:0], h[DIM_W-1:0]};
    pending_words.insert(pending_words.size(), c);
  endtask

  // wait for all queued words to drain and the block to go quiet
  task automatic drain();
    while (pending_words.size() > 0 || start || expected_places.size() > 0)
      @(negedge clk);
    repeat (2200) @(negedge clk);
  endtask

  // random small-ish rectangle, sometimes large
  function automatic int rand_dim(int lim);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 8191);
      1: return lim;
      default: return $urandom_range(1, lim);
    endcase
  endfunction

  task automatic random_phase(int n, int aw, int ah);
    int w, h;
    push_word(1, 0, 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 30) == 0) push_word(1, $urandom, $urandom);
      else begin
        w = rand_dim(aw > 4096 ? 4096 : aw);
        h = rand_dim(ah > 4096 ? 4096 : ah);
        push_word(0, w, h);
      end
    end
    drain();
  endtask

  initial begin
    int aw, ah;
    rst = 1; start = 0; command = 0; rect_width = 0; rect_height = 0;
    cfg_we = 0; cfg_index = REG_ATLAS_W; cfg_data = 0;
    m_aw = 4096; m_ah = 4096; m_rot = 0; m_merge = 1; m_prule = 0; m_srule = 2;
    clear_spans();
    repeat (3) @(negedge clk);
    rst = 0;
    repeat (4) @(negedge clk);

    // directed: reset atlas, extremes, zero sizes, exact and rotated fits
    push_word(0, 4096, 4096);
    push_word(0, 1, 1);
    push_word(1, 0, 0);
    push_word(0, 0, 5);
    push_word(0, 5, 0);
    push_word(0, 8191, 8191);
    push_word(0, 4097, 1);
    push_word(0, 100, 4096);
    push_word(0, 4096, 1);
    drain();
    write_reg(REG_ATLAS_W, 8191);
    write_reg(REG_ATLAS_H, 300);
    write_reg(REG_ROTATE, 1);
    write_reg(REG_MERGE, 0);
    write_reg(REG_PLACEMENT, PR_WORST_LONG);
    write_reg(REG_SPLIT, SR_LONGER_AXIS);
    push_word(1, 0, 0);
    push_word(0, 300, 4096);
    push_word(1, 0, 0);
    push_word(0, 300, 100);
    push_word(0, 50, 60);
    drain();
    write_reg(REG_ATLAS_W, 0);
    push_word(1, 0, 0);
    push_word(0, 1, 1);
    drain();
    write_reg(REG_ATLAS_W, 20);
    write_reg(REG_ATLAS_H, 10);
    write_reg(REG_PLACEMENT, 6);
    write_reg(REG_SPLIT, 7);
    push_word(1, 0, 0);
    push_word(0, 3, 3);
    push_word(0, 10, 20);
    drain();

    // random phases over register settings; one phase places many mid-size rects with merging off
    for (int p = 0; p < 8; p++) begin
      aw = (p == 0) ? 4096 : (p == 1) ? 1 : $urandom_range(1, 8191);
      ah = (p == 0) ? 4096 : (p == 2) ? 1 : $urandom_range(1, 8191);
      write_reg(REG_ATLAS_W, aw);
      write_reg(REG_ATLAS_H, ah);
      write_reg(REG_ROTATE, $urandom_range(0, 1));
      write_reg(REG_MERGE, $urandom_range(0, 1));
      write_reg(REG_PLACEMENT, p < 6 ? p : $urandom_range(0, 7));
      write_reg(REG_SPLIT, p < 6 ? 5 - p : $urandom_range(0, 7));
      if (p == 7) no_idle = 1;
      if (p == 3) begin
        write_reg(REG_ATLAS_W, 4096);
        write_reg(REG_ATLAS_H, 4096);
        write_reg(REG_MERGE, 0);
        push_word(1, 0, 0);
        for (int k = 0; k < 40; k++) push_word(0, $urandom_range(1, 9) * 97,
                                                $urandom_range(1, 9) * 89);
        drain();
      end else begin
        random_phase(30, aw, ah);
      end
    end

    $display("Checked %0d result words: %0d placed, %0d no fit, %0d with overflow.",
             n_checked, n_placed, n_nofit, n_ovf);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/grac_pkg.sv
rtl/grac_ram.sv
rtl/grac_ctrl.sv
rtl/grac_dp.sv
rtl/guillotine_rect_allocator_core.sv
rtl/grac_checker.sv
bench/tb_top.sv
